[rtl/mse_pkg.sv]
// mse_pkg: opcodes, function codes, syscall selectors and event codes for the
// mips subset execute step. No dependencies.
package mse_pkg;

    // sizes of the fixed fields
    localparam int INSN_W     = 32;
    localparam int LINE_W     = 10;
    localparam int LEN_W      = 11;
    localparam int EVENT_W    = 3;
    localparam int VALUE_W    = 32;
    localparam int REG_ADDR_W = 5;
    localparam int NUM_REGS   = 32;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    // default depth of the program store
    localparam int PROGRAM_DEPTH_DEF = 1024;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_SLTI    = 6'd10;
    localparam logic [5:0] OP_ANDI    = 6'd12;
    localparam logic [5:0] OP_ORI     = 6'd13;
    localparam logic [5:0] OP_LUI     = 6'd15;
    localparam logic [5:0] OP_MUL     = 6'd28;

    // function codes under the special opcode
    localparam logic [5:0] FN_SYSCALL = 6'd12;
    localparam logic [5:0] FN_ADD     = 6'd32;
    localparam logic [5:0] FN_SUB     = 6'd34;
    localparam logic [5:0] FN_AND     = 6'd36;
    localparam logic [5:0] FN_OR      = 6'd37;
    localparam logic [5:0] FN_SLT     = 6'd42;

    // fixed registers used by syscall
    localparam logic [REG_ADDR_W-1:0] REG_ZERO = 5'd0;
    localparam logic [REG_ADDR_W-1:0] REG_V0   = 5'd2;
    localparam logic [REG_ADDR_W-1:0] REG_A0   = 5'd4;

    // syscall selectors in $v0
    localparam logic [VALUE_W-1:0] SYS_PRINT_INT  = 32'd1;
    localparam logic [VALUE_W-1:0] SYS_EXIT       = 32'd10;
    localparam logic [VALUE_W-1:0] SYS_PRINT_CHAR = 32'd11;

    // event codes
    localparam logic [EVENT_W-1:0] EV_NORMAL      = 3'd0;
    localparam logic [EVENT_W-1:0] EV_PRINT_INT   = 3'd1;
    localparam logic [EVENT_W-1:0] EV_PRINT_CHAR  = 3'd2;
    localparam logic [EVENT_W-1:0] EV_EXIT        = 3'd3;
    localparam logic [EVENT_W-1:0] EV_UNKNOWN_SYS = 3'd4;
    localparam logic [EVENT_W-1:0] EV_INVALID     = 3'd5;
    localparam logic [EVENT_W-1:0] EV_OFF_PROGRAM = 3'd6;

endpackage

[rtl/mips_subset_execute_step.sv]
// mips_subset_execute_step: executes one mips subset instruction a beat against
// a 32 x 32 register file held in a synchronous two-read, one-write memory.
// Depends on mse_pkg.
//
//  channel | direction | tdata fields (low bit up)                   | tuser
//  s_      | in        | instruction_word[31:0], current_line[41:32] | -
//  m_      | out       | next_line[9:0], event_code[12:10],          | -
//          |           | out_value[44:13]                            |
//  cfg_    | in        | program_length[10:0]                        | -
//
// One instruction a cycle unless the result stalls. Register file read, then
// execute and write-back as the item moves into the output register.
// A write in execute is forwarded to the read issued at the same edge.
// Reset clears the valid bit of every register, so all read as zero at once.
// A stalled result holds the execute stage; the input side stalls only when
// the result register and the execute stage are both full and m_tready is low.
module mips_subset_execute_step #(
    parameter int PROGRAM_DEPTH = mse_pkg::PROGRAM_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // instruction_word, current_line
    input  logic [mse_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // next_line, event_code, out_value
    output logic [mse_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // program_length
    input  logic [mse_pkg::LEN_W-1:0]      cfg_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready
);
    import mse_pkg::*;

    // register file and its valid bits
    logic [VALUE_W-1:0]  rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0] rf_valid_reg;

    logic [LEN_W-1:0]      prog_len_reg;
    logic [LEN_W-1:0]      limit;

    // execute stage
    logic                  s1_valid_reg;
    logic [INSN_W-1:0]     insn_reg;
    logic [LINE_W-1:0]     line_reg;
    logic [VALUE_W-1:0]    rdata_a_reg, rdata_b_reg;
    logic                  valid_a_reg, valid_b_reg;
    logic                  fwd_a_reg, fwd_b_reg;
    logic [VALUE_W-1:0]    fwd_data_reg;

    // output register
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    logic                  s1_adv, accept;
    logic [INSN_W-1:0]     in_insn;
    logic [REG_ADDR_W-1:0] rd_addr_a, rd_addr_b;
    logic                  in_syscall;

    logic [5:0]            op, fn;
    logic [REG_ADDR_W-1:0] rt, rd;
    logic [15:0]           imm;
    logic [VALUE_W-1:0]    simm, zimm, opa, opb, product;
    logic                  wr_en;
    logic [REG_ADDR_W-1:0] wr_addr;
    logic [VALUE_W-1:0]    wr_data;
    logic                  writes, insn_ok, line_ok, taken;
    logic [16:0]           next_sum;
    logic [EVENT_W-1:0]    event_code;
    logic [VALUE_W-1:0]    out_value;
    logic [LINE_W-1:0]     next_line;
    logic [OUT_DATA_W-1:0] m_data_next;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prog_len_reg <= '0;
        end else if (cfg_valid) begin
            prog_len_reg <= cfg_data;
        end
    end

    assign limit = (32'(prog_len_reg) > PROGRAM_DEPTH) ? LEN_W'(PROGRAM_DEPTH) : prog_len_reg;

    // handshake
    assign s1_adv   = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    // read addresses: syscall reads $v0 and $a0
    assign in_insn    = s_tdata[INSN_W-1:0];
    assign in_syscall = (in_insn[31:26] == OP_SPECIAL) && (in_insn[5:0] == FN_SYSCALL);
    assign rd_addr_a  = in_syscall ? REG_V0 : in_insn[25:21];
    assign rd_addr_b  = in_syscall ? REG_A0 : in_insn[20:16];

    // memory write and registered reads
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rf_mem[wr_addr] <= wr_data;
        end
        if (accept) begin
            rdata_a_reg <= rf_mem[rd_addr_a];
            rdata_b_reg <= rf_mem[rd_addr_b];
        end
    end

    // valid bits and forwarding of the write at the read edge
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_valid_reg <= '0;
        end else if (wr_en) begin
            rf_valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            insn_reg     <= in_insn;
            line_reg     <= s_tdata[INSN_W+LINE_W-1:INSN_W];
            valid_a_reg  <= rf_valid_reg[rd_addr_a];
            valid_b_reg  <= rf_valid_reg[rd_addr_b];
            fwd_a_reg    <= wr_en && (wr_addr == rd_addr_a);
            fwd_b_reg    <= wr_en && (wr_addr == rd_addr_b);
            fwd_data_reg <= wr_data;
        end
    end

    // execute stage occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // decode
    assign op   = insn_reg[31:26];
    assign fn   = insn_reg[5:0];
    assign rt   = insn_reg[20:16];
    assign rd   = insn_reg[15:11];
    assign imm  = insn_reg[15:0];
    assign simm = {{16{imm[15]}}, imm};
    assign zimm = {16'd0, imm};

    // operands with forwarding
    assign opa = fwd_a_reg ? fwd_data_reg : (valid_a_reg ? rdata_a_reg : '0);
    assign opb = fwd_b_reg ? fwd_data_reg : (valid_b_reg ? rdata_b_reg : '0);

    assign product = opa * opb;
    assign line_ok = {1'b0, line_reg} < limit;

    // branch decision
    assign taken = ((op == OP_BEQ) && (opa == opb)) || ((op == OP_BNE) && (opa != opb));

    // next line: line + 1 or line + offset, 17-bit signed
    assign next_sum = {7'd0, line_reg} + (taken ? {imm[15], imm} : 17'd1);

    // alu, write-back data and syscall
    always_comb begin
        insn_ok    = 1'b0;
        writes     = 1'b0;
        wr_addr    = rt;
        wr_data    = '0;
        event_code = EV_NORMAL;
        out_value  = '0;
        if (op == OP_SPECIAL) begin
            insn_ok = fn inside {FN_ADD, FN_SUB, FN_AND, FN_OR, FN_SLT, FN_SYSCALL};
        end else begin
            insn_ok = op inside {OP_MUL, OP_BEQ, OP_BNE, OP_ADDI, OP_SLTI, OP_ANDI,
                                 OP_ORI, OP_LUI};
        end
        case (op)
            OP_SPECIAL: begin
                wr_addr = rd;
                writes  = (fn != FN_SYSCALL);
                case (fn)
                    FN_ADD:  wr_data = opa + opb;
                    FN_SUB:  wr_data = opa - opb;
                    FN_AND:  wr_data = opa & opb;
                    FN_OR:   wr_data = opa | opb;
                    FN_SLT:  wr_data = VALUE_W'($signed(opa) < $signed(opb));
                    FN_SYSCALL: begin
                        if (opa == SYS_PRINT_INT) begin
                            event_code = EV_PRINT_INT;
                            out_value  = opb;
                        end else if (opa == SYS_PRINT_CHAR) begin
                            event_code = EV_PRINT_CHAR;
                            out_value  = {24'd0, opb[7:0]};
                        end else if (opa == SYS_EXIT) begin
                            event_code = EV_EXIT;
                        end else begin
                            event_code = EV_UNKNOWN_SYS;
                            out_value  = opa;
                        end
                    end
                    default: wr_data = '0;
                endcase
            end
            OP_MUL: begin
                wr_addr = rd;
                writes  = 1'b1;
                wr_data = product;
            end
            OP_BEQ, OP_BNE: writes = 1'b0;
            OP_ADDI: begin
                writes  = 1'b1;
                wr_data = opa + simm;
            end
            OP_SLTI: begin
                writes  = 1'b1;
                wr_data = VALUE_W'($signed(opa) < $signed(simm));
            end
            OP_ANDI: begin
                writes  = 1'b1;
                wr_data = opa & zimm;
            end
            OP_ORI: begin
                writes  = 1'b1;
                wr_data = opa | zimm;
            end
            OP_LUI: begin
                writes  = 1'b1;
                wr_data = {imm, 16'd0};
            end
            default: writes = 1'b0;
        endcase

        // program edge and invalid opcode override everything
        if (!line_ok) begin
            event_code = EV_OFF_PROGRAM;
            out_value  = '0;
        end else if (!insn_ok) begin
            event_code = EV_INVALID;
            out_value  = '0;
        end else if (event_code == EV_NORMAL) begin
            if (next_sum[16] || (next_sum[15:0] >= 16'(limit))) begin
                event_code = EV_OFF_PROGRAM;
            end
        end
    end

    assign next_line = (event_code < EV_EXIT) ? next_sum[LINE_W-1:0] : '0;

    // write-back happens once, when the item leaves execute
    assign wr_en = s1_valid_reg && s1_adv && line_ok && insn_ok && writes &&
                   (wr_addr != REG_ZERO);

    // output register
    assign m_data_next = {3'd0, out_value, event_code, next_line};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_valid_reg && s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s1_adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // checks
    a_no_zero_write: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> wr_addr != REG_ZERO)
        else $error("write to register zero");

    a_line_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[12:10] >= EV_EXIT) |-> m_tdata[9:0] == '0)
        else $error("next line not cleared for a stopping event");

    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[12:10] == EV_NORMAL || m_tdata[12:10] == EV_EXIT ||
                      m_tdata[12:10] == EV_INVALID || m_tdata[12:10] == EV_OFF_PROGRAM))
        |-> m_tdata[44:13] == '0)
        else $error("value not cleared for an event without value");

    a_one_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && !accept) |=> !wr_en)
        else $error("item written back twice");

endmodule

[tb/sv/tb_mips_subset_execute_step.sv]
// tb_mips_subset_execute_step: self-checking bench for the mips subset execute step.
// Shadows the register file and program length and checks every result beat in order.
// Depends on mse_pkg and mips_subset_execute_step.
module tb_mips_subset_execute_step;
    timeunit 1ns;
    timeprecision 1ps;

    import mse_pkg::*;

    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(PROGRAM_DEPTH_DEF);

    typedef struct packed {
        logic [LINE_W-1:0]  next_line;
        logic [EVENT_W-1:0] event_code;
        logic [VALUE_W-1:0] out_value;
    } step_result_t;

    // dut ports; the inputs are all known from time zero
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [LEN_W-1:0]      cfg_data  = '0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;

    // shadow state of the execute step
    logic [VALUE_W-1:0] shadow_regs [NUM_REGS];
    logic [LEN_W-1:0]   prog_len;
    step_result_t       pending_results [$];

    // stimulus knobs and counters
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    logic [10:0] stim_limit     = '0;
    int          n_sent         = 0;
    int          n_checked      = 0;
    int          n_errors       = 0;
    int          n_cfg          = 0;

    mips_subset_execute_step dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),   // instruction_word[31:0], current_line[41:32]
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),   // next_line[9:0], event_code[12:10], out_value[44:13]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),  // program_length[10:0]
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic logic is_legal(input logic [5:0] op, input logic [5:0] fn);
        if (op == OP_SPECIAL)
            return fn inside {FN_ADD, FN_SUB, FN_AND, FN_OR, FN_SLT, FN_SYSCALL};
        return op inside {OP_MUL, OP_BEQ, OP_BNE, OP_ADDI, OP_SLTI, OP_ANDI, OP_ORI, OP_LUI};
    endfunction

    function automatic void set_reg(input logic [4:0] idx, input logic [31:0] val);
        if (idx != REG_ZERO)
            shadow_regs[idx] = val;
    endfunction

    // executes one instruction on the shadow registers and returns its result beat
    function automatic step_result_t execute_insn(input logic [31:0] word,
                                                  input logic [9:0] line);
        logic [5:0]   op, fn;
        logic [4:0]   rs, rt, rd;
        logic [15:0]  imm;
        logic [31:0]  simm, a, b, v0, a0;
        logic [10:0]  lim;
        int           next_ln;
        step_result_t res;
        op      = word[31:26];
        rs      = word[25:21];
        rt      = word[20:16];
        rd      = word[15:11];
        fn      = word[5:0];
        imm     = word[15:0];
        simm    = {{16{imm[15]}}, imm};
        a       = shadow_regs[rs];
        b       = shadow_regs[rt];
        v0      = shadow_regs[REG_V0];
        a0      = shadow_regs[REG_A0];
        lim     = (prog_len > LEN_CAP) ? LEN_CAP : prog_len;
        next_ln = int'(line) + 1;
        res     = '0;

        // line outside the loaded program executes nothing
        if ({1'b0, line} >= lim) begin
            res.event_code = EV_OFF_PROGRAM;
            return res;
        end
        if (!is_legal(op, fn)) begin
            res.event_code = EV_INVALID;
            return res;
        end

        case (op)
            OP_SPECIAL: begin
                case (fn)
                    FN_ADD: set_reg(rd, a + b);
                    FN_SUB: set_reg(rd, a - b);
                    FN_AND: set_reg(rd, a & b);
                    FN_OR:  set_reg(rd, a | b);
                    FN_SLT: set_reg(rd, {31'd0, $signed(a) < $signed(b)});
                    default: begin
                        // syscall, selected by $v0
                        if (v0 == SYS_PRINT_INT) begin
                            res.event_code = EV_PRINT_INT;
                            res.out_value  = a0;
                        end else if (v0 == SYS_PRINT_CHAR) begin
                            res.event_code = EV_PRINT_CHAR;
                            res.out_value  = {24'd0, a0[7:0]};
                        end else if (v0 == SYS_EXIT) begin
                            res.event_code = EV_EXIT;
                        end else begin
                            res.event_code = EV_UNKNOWN_SYS;
                            res.out_value  = v0;
                        end
                    end
                endcase
            end
            OP_MUL:  set_reg(rd, a * b);
            OP_BEQ:  if (a == b) next_ln = int'(line) + int'($signed(imm));
            OP_BNE:  if (a != b) next_ln = int'(line) + int'($signed(imm));
            OP_ADDI: set_reg(rt, a + simm);
            OP_SLTI: set_reg(rt, {31'd0, $signed(a) < $signed(simm)});
            OP_ANDI: set_reg(rt, a & {16'd0, imm});
            OP_ORI:  set_reg(rt, a | {16'd0, imm});
            default: set_reg(rt, {imm, 16'd0});
        endcase

        // a normal step that leaves the program runs off its end
        if (res.event_code == EV_NORMAL && (next_ln < 0 || next_ln >= int'(lim)))
            res.event_code = EV_OFF_PROGRAM;
        if (res.event_code < EV_EXIT)
            res.next_line = next_ln[9:0];
        return res;
    endfunction

    // prediction on accepted beats, in-order comparison of result beats
    always @(posedge aclk) begin
        step_result_t got, want;
        if (!aresetn) begin
            foreach (shadow_regs[k])
                shadow_regs[k] = '0;
            prog_len = '0;
        end else begin
            if (cfg_valid && cfg_ready)
                prog_len = cfg_data;
            if (s_tvalid && s_tready)
                pending_results.push_back(execute_insn(s_tdata[31:0], s_tdata[41:32]));
            if (m_tvalid && m_tready) begin
                got.next_line  = m_tdata[9:0];
                got.event_code = m_tdata[12:10];
                got.out_value  = m_tdata[44:13];
                n_checked++;
                if (pending_results.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("result beat %0d arrived with none expected: next %0d ev %0d val %h",
                                 n_checked, got.next_line, got.event_code, got.out_value);
                end else begin
                    want = pending_results.pop_front();
                    if (got.next_line !== want.next_line || got.event_code !== want.event_code ||
                        got.out_value !== want.out_value) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("result beat %0d: expected next %0d ev %0d val %h, got next %0d ev %0d val %h",
                                     n_checked, want.next_line, want.event_code, want.out_value,
                                     got.next_line, got.event_code, got.out_value);
                    end
                end
            end
        end
    end

    function automatic logic [31:0] enc_r(input logic [5:0] op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [4:0] rd,
                                          input logic [5:0] fn);
        return {op, rs, rt, rd, 5'd0, fn};
    endfunction

    function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // sends one instruction beat, with a random idle gap ahead of it
    task automatic send_insn(input logic [31:0] word, input logic [9:0] line);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tdata  <= {6'd0, line, word};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_sent++;
    endtask

    // waits until every expected result beat has come out, then lets the pipe settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_program_length(input logic [10:0] len);
        wait_idle();
        cfg_data  <= len;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        stim_limit = (len > LEN_CAP) ? LEN_CAP : len;
        n_cfg++;
    endtask

    // program length is zero after reset, so any line is off the program
    task automatic test_reset_length_zero();
        send_insn(enc_r(OP_SPECIAL, 5'd1, 5'd2, 5'd3, FN_ADD), 10'd0);
    endtask

    // every alu and immediate op, with sign and zero extension corners
    task automatic test_alu_and_immediates();
        send_insn(enc_i(OP_LUI,  REG_ZERO, 5'd1, 16'h8000), 10'd0);
        send_insn(enc_i(OP_ORI,  5'd1, 5'd1, 16'hFFFF), 10'd1);
        send_insn(enc_i(OP_ANDI, 5'd1, 5'd3, 16'h8001), 10'd2);
        send_insn(enc_i(OP_ADDI, REG_ZERO, 5'd2, 16'hFFFF), 10'd3);
        send_insn(enc_r(OP_SPECIAL, 5'd1, 5'd2, 5'd4, FN_ADD), 10'd4);
        send_insn(enc_r(OP_SPECIAL, REG_ZERO, 5'd1, 5'd5, FN_SUB), 10'd5);
        send_insn(enc_r(OP_SPECIAL, 5'd1, 5'd2, 5'd6, FN_AND), 10'd6);
        send_insn(enc_r(OP_SPECIAL, 5'd3, 5'd2, 5'd7, FN_OR), 10'd7);
        send_insn(enc_r(OP_SPECIAL, 5'd1, 5'd2, 5'd8, FN_SLT), 10'd8);
        send_insn(enc_i(OP_SLTI, 5'd2, 5'd9, 16'h8000), 10'd9);
        send_insn(enc_r(OP_MUL, 5'd1, 5'd2, 5'd10, FN_ADD), 10'd10);
        // register zero stays zero
        send_insn(enc_i(OP_ADDI, REG_ZERO, REG_ZERO, 16'd5), 10'd11);
    endtask

    // taken and untaken branches, into and out of the program
    task automatic test_branches();
        send_insn(enc_i(OP_BEQ, REG_ZERO, REG_ZERO, -16'sd5), 10'd3);
        send_insn(enc_i(OP_BNE, 5'd1, 5'd2, 16'd2), 10'd1021);
        send_insn(enc_i(OP_BNE, 5'd1, 5'd2, 16'd2), 10'd1022);
        send_insn(enc_i(OP_BEQ, 5'd1, 5'd2, 16'd100), 10'd5);
    endtask

    // every syscall kind, with a print on the last line of the program
    task automatic test_syscalls();
        send_insn(enc_i(OP_ADDI, REG_ZERO, REG_V0, 16'(SYS_PRINT_INT)), 10'd20);
        send_insn(enc_i(OP_ADDI, REG_ZERO, REG_A0, -16'sd7), 10'd21);
        send_insn(enc_r(OP_SPECIAL, REG_ZERO, REG_ZERO, REG_ZERO, FN_SYSCALL), 10'd1023);
        send_insn(enc_i(OP_ADDI, REG_ZERO, REG_V0, 16'(SYS_PRINT_CHAR)), 10'd22);
        send_insn(enc_r(OP_SPECIAL, REG_ZERO, REG_ZERO, REG_ZERO, FN_SYSCALL), 10'd23);
        send_insn(enc_i(OP_ADDI, REG_ZERO, REG_V0, 16'(SYS_EXIT)), 10'd24);
        send_insn(enc_r(OP_SPECIAL, REG_ZERO, REG_ZERO, REG_ZERO, FN_SYSCALL), 10'd25);
        send_insn(enc_i(OP_ADDI, REG_ZERO, REG_V0, -16'sd3), 10'd26);
        send_insn(enc_r(OP_SPECIAL, REG_ZERO, REG_ZERO, REG_ZERO, FN_SYSCALL), 10'd27);
    endtask

    // unknown opcode, and unknown function code under the special opcode
    task automatic test_invalid_codes();
        send_insn({6'h3F, 26'h3FF_FFFF}, 10'd30);
        send_insn(enc_r(OP_SPECIAL, 5'd1, 5'd2, 5'd3, 6'd0), 10'd31);
    endtask

    function automatic logic [4:0] pick_reg();
        return ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
    endfunction

    // mostly inside the program, sometimes its last line or anywhere
    function automatic logic [9:0] pick_line();
        int r;
        r = $urandom_range(9);
        if (stim_limit == 0 || r == 0)
            return 10'($urandom);
        if (r == 1)
            return 10'(stim_limit - 1);
        return 10'($urandom_range(stim_limit - 1));
    endfunction

    // random instruction runs: syscall set-ups, branches, alu work, invalid codes and noise
    task automatic test_random_traffic(input int n_items);
        int          kind, start;
        logic [9:0]  ln;
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt;
        logic [15:0] imm;
        start = n_sent;
        while (n_sent - start < n_items) begin
            kind = $urandom_range(99);
            ln   = pick_line();
            rs   = pick_reg();
            rt   = ($urandom_range(4) == 0) ? rs : pick_reg();
            imm  = 16'($urandom);
            if (kind < 10) begin
                send_insn($urandom, ln);
            end else if (kind < 15) begin
                do begin
                    op = $urandom_range(1) ? OP_SPECIAL : 6'($urandom);
                    fn = 6'($urandom);
                end while (is_legal(op, fn));
                send_insn({op, 20'($urandom), fn}, ln);
            end else if (kind < 32) begin
                // set $v0 and $a0, then call
                case ($urandom_range(3))
                    0:       imm = 16'(SYS_PRINT_INT);
                    1:       imm = 16'(SYS_PRINT_CHAR);
                    2:       imm = 16'(SYS_EXIT);
                    default: imm = 16'($urandom);
                endcase
                send_insn(enc_i(OP_ADDI, REG_ZERO, REG_V0, imm), ln);
                ln++;
                if ($urandom_range(1))
                    send_insn(enc_i(OP_LUI, REG_ZERO, REG_A0, 16'($urandom)), ln);
                else
                    send_insn(enc_i(OP_ADDI, REG_ZERO, REG_A0, 16'($urandom)), ln);
                ln++;
                send_insn({OP_SPECIAL, 20'($urandom), FN_SYSCALL}, ln);
            end else if (kind < 47) begin
                if ($urandom_range(1)) begin
                    imm = 16'($urandom_range(40));
                    imm = imm - 16'd20;
                end
                send_insn(enc_i($urandom_range(1) ? OP_BEQ : OP_BNE, rs, rt, imm), ln);
            end else begin
                case ($urandom_range(10))
                    0:  op = OP_ADDI;
                    1:  op = OP_SLTI;
                    2:  op = OP_ANDI;
                    3:  op = OP_ORI;
                    4:  op = OP_LUI;
                    5:  op = OP_MUL;
                    default: op = OP_SPECIAL;
                endcase
                case ($urandom_range(4))
                    0:       fn = FN_ADD;
                    1:       fn = FN_SUB;
                    2:       fn = FN_AND;
                    3:       fn = FN_OR;
                    default: fn = FN_SLT;
                endcase
                if (op == OP_SPECIAL || op == OP_MUL)
                    send_insn({op, rs, rt, pick_reg(), 5'($urandom), fn}, ln);
                else
                    send_insn(enc_i(op, rs, pick_reg(), imm), ln);
            end
        end
    endtask

    // one handshake pressure phase over two program lengths
    task automatic test_random_phase(input int src_pct, input int stall_pct,
                                     input logic [10:0] len_a, input logic [10:0] len_b);
        src_idle_pct   = src_pct;
        sink_stall_pct = stall_pct;
        write_program_length(len_a);
        test_random_traffic((len_a < 2) ? 30 : 140);
        write_program_length(len_b);
        test_random_traffic((len_b < 2) ? 30 : 140);
    endtask

    // test sequence
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_length_zero();
        write_program_length(11'h7FF);
        test_alu_and_immediates();
        test_branches();
        test_syscalls();
        test_invalid_codes();

        test_random_phase(0, 0, 11'd2047, 11'd64);
        test_random_phase(50, 0, 11'd1024, 11'd0);
        test_random_phase(0, 50, 11'd1, 11'd300);
        test_random_phase(36, 36, 11'd16, 11'd1023);

        wait_idle();
        $display("covered %0d instructions under %0d program length settings", n_sent, n_cfg);
        $display("checked %0d result beats across free, sender idle, receiver stall and mixed phases",
                 n_checked);
        if (n_errors == 0)
            $display("** mips_subset_execute_step: PASSED **");
        else
            $display("** mips_subset_execute_step: FAILED **");
        $finish;
    end

    // run limit
    initial begin
        #1_000_000;
        $display("timeout with %0d result beats outstanding", pending_results.size());
        $display("** mips_subset_execute_step: FAILED **");
        $finish;
    end

endmodule
